// ===== src/lru_page_frame_directory_core_macros.svh =====
// Assertion macros shared by the checker of the page frame directory core.
// Depends on nothing.
`ifndef LRU_PAGE_FRAME_DIRECTORY_CORE_MACROS_SVH
`define LRU_PAGE_FRAME_DIRECTORY_CORE_MACROS_SVH
`define PFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/pfd_pkg.sv =====
// Package of the page frame directory: sizes, status and action codes, cell types.
// Depends on nothing.
package pfd_pkg;
    localparam int PoolFrames = 256;
    localparam int EvictBatch = 64;
    localparam int FrameW = $clog2(PoolFrames);
    localparam int CountW = $clog2(PoolFrames + 1);
    localparam int BatchW = $clog2(EvictBatch + 1);

    localparam logic [1:0] ACT_GET = 2'd0;
    localparam logic [1:0] ACT_NEW = 2'd1;
    localparam logic [1:0] ACT_DIRTY = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam logic [2:0] ST_HIT = 3'd0;
    localparam logic [2:0] ST_LOADED = 3'd1;
    localparam logic [2:0] ST_BLANK = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_HELD = 3'd4;
    localparam logic [2:0] ST_BEYOND = 3'd5;
    localparam logic [2:0] ST_EVICT = 3'd6;
    localparam logic [2:0] ST_MARKED = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_EVICT, S_ALLOC, S_OUT
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [FrameW-1:0] frame;
        logic [31:0] space;
        logic [31:0] page;
        logic        dirty;
    } t_entry;

    // Command from the controller to every cell of the LRU chain.
    typedef struct packed {
        logic        compare;
        logic        promote;
        logic        insert;
        logic        drop_tail;
        logic        mark;
        logic [31:0] space;
        logic [31:0] page;
        logic [FrameW-1:0] frame;
        t_entry      head;
    } t_cmd;
endpackage

// ===== src/pfd_cell.sv =====
// One cell of the LRU chain: holds one directory entry and shifts toward the tail.
// Depends on pfd_pkg.
module pfd_cell import pfd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  t_entry i_prev,
    input  logic   i_shift_in,
    input  logic   i_is_tail,
    output t_entry o_entry,
    output logic   o_match,
    output logic   o_shift_out
);
    t_entry r_entry;
    t_entry n_entry;
    logic   w_hit;
    logic   w_shift;

    assign w_hit = r_entry.valid && r_entry.space == i_cmd.space
        && r_entry.page == i_cmd.page;
    assign o_match = w_hit;
    // A promote shifts every cell up to and including the matching one.
    assign w_shift = i_cmd.insert || (i_cmd.promote && i_shift_in);
    assign o_shift_out = i_cmd.promote ? (i_shift_in && !w_hit) : 1'b0;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (w_shift) begin
            n_entry = i_prev;
        end else if (i_cmd.drop_tail && i_is_tail) begin
            n_entry.valid = 1'b0;
        end else if (i_cmd.mark && r_entry.valid && r_entry.frame == i_cmd.frame) begin
            n_entry.dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.frame <= n_entry.frame;
        r_entry.space <= n_entry.space;
        r_entry.page <= n_entry.page;
        r_entry.dirty <= n_entry.dirty;
    end
endmodule

// ===== src/pfd_chain.sv =====
// Row of LRU cells, most recent first, with the hit search result.
// Depends on pfd_pkg and pfd_cell.
module pfd_chain import pfd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  logic [CountW-1:0] i_count,
    output logic   o_hit,
    output t_entry o_hit_entry,
    output t_entry o_tail
);
    t_entry w_ent [PoolFrames];
    logic   w_match [PoolFrames];
    logic   w_sh [PoolFrames+1];
    t_entry w_head;

    always_comb begin
        w_head = i_cmd.head;
        if (i_cmd.promote) begin
            w_head = o_hit_entry;
        end
    end

    assign w_sh[0] = 1'b1;

    for (genvar g = 0; g < PoolFrames; g++) begin : g_cell
        pfd_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd),
            .i_prev((g == 0) ? w_head : w_ent[(g == 0) ? 0 : g-1]),
            .i_shift_in(w_sh[g]),
            .i_is_tail(i_count == CountW'(g + 1)),
            .o_entry(w_ent[g]), .o_match(w_match[g]), .o_shift_out(w_sh[g+1])
        );
    end

    always_comb begin
        o_hit = 1'b0;
        o_hit_entry = '0;
        for (int k = 0; k < PoolFrames; k++) begin
            if (w_match[k]) begin
                o_hit = 1'b1;
                o_hit_entry = o_hit_entry | w_ent[k];
            end
        end
    end

    always_comb begin
        o_tail = w_ent[0];
        if (i_count != '0) begin
            o_tail = w_ent[FrameW'(i_count - CountW'(1))];
        end
    end
endmodule

// ===== src/lru_page_frame_directory_core.sv =====
// LRU page frame directory: request, result and the eviction controller.
// The input channel takes one request transaction with action, space, page and
// flags. The output channel gives one or more result transactions; the final
// one has o_last high and carries the status and granted frame. A request with
// the undefined action code is accepted and gives no result.
// A request is accepted only when the previous one has delivered all results.
// A hit, mark, refusal or miss with a free frame passes from the search state through
// the allocate state to its result, with no eviction.
// With no free frame, up to 64 least recent frames are evicted first, one tail cell
// dropped and one result per cycle while the receiver does not stall.
// The search is one compare in every chain cell followed by one registered step.
// After reset the free list is filled with frames in ascending order, during
// which o_ready stays low; the LRU chain starts empty.
// When the receiver stalls, the pending result holds on the output and the
// controller waits; nothing is lost.
module lru_page_frame_directory_core import pfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_space_num,
    input  logic [31:0] i_page_num,
    input  logic        i_space_known,
    input  logic        i_page_on_disk,
    input  logic [7:0]  i_dirty_frame,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_granted_frame,
    output logic        o_evict_valid,
    output logic [7:0]  o_evicted_frame,
    output logic [31:0] o_evicted_space,
    output logic [31:0] o_evicted_page,
    output logic        o_write_back,
    output logic        o_last
);
    t_state r_state, n_state;
    logic [1:0]  r_act;
    logic [31:0] r_sp, r_pg;
    logic        r_known, r_disk;
    logic [7:0]  r_df;
    logic [CountW-1:0] r_lru_cnt, r_free_cnt;
    logic [FrameW-1:0] r_free_head;
    logic [FrameW-1:0] r_fifo [PoolFrames];
    logic [FrameW-1:0] r_fifo_rd;
    logic [BatchW-1:0] r_nev;
    logic        r_hit;
    t_entry      r_hit_ent;
    logic        r_ov;
    logic [2:0]  r_st;
    logic [7:0]  r_gf;
    t_entry      r_ev;
    logic        r_evv;
    logic        r_last;
    logic        r_fill;
    logic [FrameW-1:0] r_fill_idx;

    t_cmd   w_cmd;
    logic   w_hit;
    t_entry w_hit_ent, w_tail;
    logic   w_out_free;
    logic   w_evict_go;
    logic   w_last_ev;

    assign w_out_free = !r_ov || i_ready;
    assign o_ready = (r_state == S_IDLE) && !r_fill && !r_ov;
    assign w_evict_go = (r_nev != BatchW'(EvictBatch)) && (r_lru_cnt != '0);
    assign w_last_ev = !((r_nev + BatchW'(1)) != BatchW'(EvictBatch) && r_lru_cnt > CountW'(1));

    pfd_chain u_chain (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_count(r_lru_cnt),
        .o_hit(w_hit), .o_hit_entry(w_hit_ent), .o_tail(w_tail)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_act == ACT_NONE) begin
                    n_state = S_IDLE;
                end else if (r_act == ACT_DIRTY || (r_act == ACT_GET && !r_known)
                        || r_hit || r_free_cnt != '0) begin
                    n_state = S_ALLOC;
                end else begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                if (w_out_free && w_evict_go && w_last_ev) begin
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (w_out_free) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_cmd = '0;
        w_cmd.space = r_sp;
        w_cmd.page = r_pg;
        w_cmd.frame = r_df[FrameW-1:0];
        w_cmd.head.valid = 1'b1;
        w_cmd.head.frame = r_fifo_rd;
        w_cmd.head.space = r_sp;
        w_cmd.head.page = r_pg;
        w_cmd.head.dirty = 1'b0;
        unique case (r_state)
            S_EVICT: w_cmd.drop_tail = w_out_free && w_evict_go;
            S_ALLOC: begin
                if (w_out_free && r_nev == '0 && r_act == ACT_DIRTY) begin
                    w_cmd.mark = 1'b1;
                end else if (w_out_free && r_act != ACT_DIRTY
                        && !(r_act == ACT_GET && !r_known)) begin
                    if (r_hit) begin
                        w_cmd.promote = (r_act == ACT_GET);
                    end else if (!(r_act == ACT_GET && !r_disk) && r_free_cnt != '0) begin
                        w_cmd.insert = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lru_cnt <= '0;
            r_free_cnt <= CountW'(PoolFrames);
            r_free_head <= '0;
            r_ov <= 1'b0;
            r_fill <= 1'b1;
            r_fill_idx <= '0;
            r_nev <= '0;
        end else begin
            r_state <= n_state;
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (r_fill) begin
                r_fill_idx <= r_fill_idx + FrameW'(1);
                if (r_fill_idx == FrameW'(PoolFrames - 1)) begin
                    r_fill <= 1'b0;
                end
            end
            if (r_state == S_IDLE) begin
                r_nev <= '0;
            end
            if (w_cmd.drop_tail) begin
                r_lru_cnt <= r_lru_cnt - CountW'(1);
                r_free_cnt <= r_free_cnt + CountW'(1);
                r_nev <= r_nev + BatchW'(1);
                r_ov <= !w_last_ev;
            end
            if (w_cmd.insert) begin
                r_lru_cnt <= r_lru_cnt + CountW'(1);
                r_free_cnt <= r_free_cnt - CountW'(1);
                r_free_head <= r_free_head + FrameW'(1);
            end
            if (r_state == S_ALLOC && w_out_free) begin
                r_ov <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fifo_rd <= r_fifo[r_free_head];
        if (r_fill) begin
            r_fifo[r_fill_idx] <= r_fill_idx;
        end else if (w_cmd.drop_tail) begin
            r_fifo[FrameW'(r_free_head + r_free_cnt[FrameW-1:0])] <= w_tail.frame;
        end
        if (i_valid && o_ready) begin
            r_act <= i_action;
            r_sp <= i_space_num;
            r_pg <= i_page_num;
            r_known <= i_space_known;
            r_disk <= i_page_on_disk;
            r_df <= i_dirty_frame;
        end
        if (r_state == S_SEARCH) begin
            r_hit <= w_hit;
            r_hit_ent <= w_hit_ent;
        end
        if (w_cmd.drop_tail) begin
            r_ev <= w_tail;
            r_evv <= 1'b1;
            r_st <= ST_EVICT;
            r_gf <= '0;
            r_last <= 1'b0;
        end
        if (r_state == S_ALLOC && w_out_free) begin
            r_last <= 1'b1;
            r_gf <= '0;
            if (r_nev == '0) begin
                r_evv <= 1'b0;
                r_ev <= '0;
            end
            if (r_act == ACT_DIRTY) begin
                r_st <= ST_MARKED;
            end else if (r_act == ACT_GET && !r_known) begin
                r_st <= ST_UNKNOWN;
            end else if (r_hit) begin
                r_st <= (r_act == ACT_GET) ? ST_HIT : ST_HELD;
                r_gf <= (r_act == ACT_GET) ? 8'(r_hit_ent.frame) : '0;
            end else if ((r_act == ACT_GET && !r_disk) || r_free_cnt == '0) begin
                r_st <= ST_BEYOND;
            end else begin
                r_st <= (r_act == ACT_GET) ? ST_LOADED : ST_BLANK;
                r_gf <= 8'(r_fifo_rd);
            end
        end
    end

    assign o_valid = r_ov;
    assign o_status = r_st;
    assign o_granted_frame = r_gf;
    assign o_evict_valid = r_evv;
    assign o_evicted_frame = r_evv ? 8'(r_ev.frame) : '0;
    assign o_evicted_space = r_evv ? r_ev.space : '0;
    assign o_evicted_page = r_evv ? r_ev.page : '0;
    assign o_write_back = r_evv && r_ev.dirty;
    assign o_last = r_last;
endmodule

// ===== src/pfd_checker.sv =====
// Port checker for the page frame directory core, bound to the top level.
// Depends on pfd_pkg and the macros header.
`include "lru_page_frame_directory_core_macros.svh"
module pfd_checker import pfd_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_status,
    input logic       o_evict_valid,
    input logic       o_last
);
    `PFD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status))
    `PFD_ASSERT_IMP(a_mid_evict, i_clk, i_rst_n, o_valid && !o_last, o_evict_valid)
    `PFD_ASSERT_IMP(a_mid_status, i_clk, i_rst_n, o_valid && !o_last, o_status == ST_EVICT)
    `PFD_ASSERT_IMP(a_busy, i_clk, i_rst_n, o_valid, !o_ready)
endmodule

bind lru_page_frame_directory_core pfd_checker u_pfd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_evict_valid(o_evict_valid), .o_last(o_last)
);

// ===== bench/lru_page_frame_directory_core_tb.sv =====
// Testbench of the LRU page frame directory core: a directed and random request stream
// is checked result by result against a behavioral directory model kept in the bench.
// Depends on pfd_pkg and lru_page_frame_directory_core.
module lru_page_frame_directory_core_tb;
    import pfd_pkg::*;

    typedef struct {
        logic [1:0]  action;
        logic [31:0] space_num;
        logic [31:0] page_num;
        logic        space_known;
        logic        page_on_disk;
        logic [7:0]  dirty_frame;
    } t_req;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  granted;
        logic        evict_valid;
        logic [7:0]  ev_frame;
        logic [31:0] ev_space;
        logic [31:0] ev_page;
        logic        write_back;
        logic        last;
    } t_res;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  in_action = '0;
    logic [31:0] in_space = '0;
    logic [31:0] in_page = '0;
    logic        in_known = 1'b0;
    logic        in_on_disk = 1'b0;
    logic [7:0]  in_dframe = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  out_status;
    logic [7:0]  out_granted;
    logic        out_evict_valid;
    logic [7:0]  out_ev_frame;
    logic [31:0] out_ev_space;
    logic [31:0] out_ev_page;
    logic        out_write_back;
    logic        out_last;

    lru_page_frame_directory_core uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_action(in_action), .i_space_num(in_space), .i_page_num(in_page),
        .i_space_known(in_known), .i_page_on_disk(in_on_disk),
        .i_dirty_frame(in_dframe), .o_valid(out_valid), .i_ready(out_ready),
        .o_status(out_status), .o_granted_frame(out_granted),
        .o_evict_valid(out_evict_valid), .o_evicted_frame(out_ev_frame),
        .o_evicted_space(out_ev_space), .o_evicted_page(out_ev_page),
        .o_write_back(out_write_back), .o_last(out_last)
    );

    always #2 clk = ~clk;

    // Directory model state.
    logic [31:0] dir_space [PoolFrames];
    logic [31:0] dir_page [PoolFrames];
    logic        dir_used [PoolFrames];
    logic        dir_dirty [PoolFrames];
    int          recency [$];
    int          free_frames [$];

    t_req        pending_reqs [$];
    t_res        expected_results [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          recv_hold = 1'b0;
    bit          stim_done = 1'b0;
    int          quiet_cycles = 0;

    function automatic t_res blank_result(logic [2:0] st, logic [7:0] gr);
        t_res r;
        r = '{st, gr, 1'b0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b1};
        return r;
    endfunction

    task automatic expect_result(input t_res r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic predict_request(input t_req q);
        int   pos;
        int   f;
        int   n;
        t_res r;
        logic [2:0] st;
        logic [7:0] gr;
        pos = -1;
        n = 0;
        gr = 8'd0;
        if (q.action == ACT_DIRTY) begin
            if (dir_used[q.dirty_frame]) dir_dirty[q.dirty_frame] = 1'b1;
            expect_result(blank_result(ST_MARKED, 8'd0));
            return;
        end
        if (q.action != ACT_GET && q.action != ACT_NEW) return;
        if (q.action == ACT_GET && !q.space_known) begin
            expect_result(blank_result(ST_UNKNOWN, 8'd0));
            return;
        end
        foreach (recency[i]) begin
            if (pos < 0 && dir_space[recency[i]] == q.space_num
                    && dir_page[recency[i]] == q.page_num) pos = i;
        end
        if (pos >= 0) begin
            if (q.action == ACT_NEW) begin
                expect_result(blank_result(ST_HELD, 8'd0));
            end else begin
                f = recency[pos];
                recency.delete(pos);
                recency.push_front(f);
                expect_result(blank_result(ST_HIT, f[7:0]));
            end
            return;
        end
        if (free_frames.size() == 0) begin
            while (n < EvictBatch && recency.size() > 0) begin
                f = recency[$];
                recency.delete(recency.size() - 1);
                r = '{ST_EVICT, 8'd0, 1'b1, f[7:0], dir_space[f], dir_page[f],
                      dir_dirty[f], 1'b0};
                dir_used[f] = 1'b0;
                dir_dirty[f] = 1'b0;
                free_frames.insert(free_frames.size(), f);
                expect_result(r);
                n++;
            end
        end
        if ((q.action == ACT_GET && !q.page_on_disk) || free_frames.size() == 0) begin
            st = ST_BEYOND;
        end else begin
            f = free_frames[0];
            free_frames.delete(0);
            dir_space[f] = q.space_num;
            dir_page[f] = q.page_num;
            dir_used[f] = 1'b1;
            dir_dirty[f] = 1'b0;
            recency.push_front(f);
            gr = f[7:0];
            st = (q.action == ACT_GET) ? ST_LOADED : ST_BLANK;
        end
        if (n > 0) begin
            r = expected_results[$];
            r.status = st;
            r.granted = gr;
            r.last = 1'b1;
            expected_results[expected_results.size() - 1] = r;
        end else begin
            expect_result(blank_result(st, gr));
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Driver.
    always @(posedge clk) begin
        t_req q;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                predict_request('{in_action, in_space, in_page, in_known, in_on_disk,
                                  in_dframe});
            end
            if ((!in_valid || in_ready) && pending_reqs.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                q = pending_reqs[0];
                pending_reqs.delete(0);
                in_valid <= 1'b1;
                in_action <= q.action;
                in_space <= q.space_num;
                in_page <= q.page_num;
                in_known <= q.space_known;
                in_on_disk <= q.page_on_disk;
                in_dframe <= q.dirty_frame;
            end else if (in_valid && in_ready) begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver.
    always @(posedge clk) begin
        t_res e;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, 32'd0);
                end else begin
                    e = expected_results[0];
                    expected_results.delete(0);
                    if (out_status !== e.status)
                        report_mismatch("status", 32'(out_status), 32'(e.status));
                    if (out_granted !== e.granted)
                        report_mismatch("granted_frame", 32'(out_granted), 32'(e.granted));
                    if (out_evict_valid !== e.evict_valid)
                        report_mismatch("evict_valid", 32'(out_evict_valid),
                                        32'(e.evict_valid));
                    if (out_ev_frame !== e.ev_frame)
                        report_mismatch("evicted_frame", 32'(out_ev_frame), 32'(e.ev_frame));
                    if (out_ev_space !== e.ev_space)
                        report_mismatch("evicted_space", out_ev_space, e.ev_space);
                    if (out_ev_page !== e.ev_page)
                        report_mismatch("evicted_page", out_ev_page, e.ev_page);
                    if (out_write_back !== e.write_back)
                        report_mismatch("write_back", 32'(out_write_back), 32'(e.write_back));
                    if (out_last !== e.last)
                        report_mismatch("last", 32'(out_last), 32'(e.last));
                end
            end
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_req make_req(logic [1:0] a, logic [31:0] s, logic [31:0] p,
                                      logic k, logic d, logic [7:0] df);
        t_req q;
        q = '{a, s, p, k, d, df};
        return q;
    endfunction

    task automatic add_req(input t_req q);
        pending_reqs.insert(pending_reqs.size(), q);
    endtask

    // Well-formed traffic over a small page set so that hits, fills and evictions occur.
    task automatic queue_random(input int count);
        t_req q;
        int   pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            q = make_req(ACT_GET, $urandom_range(3), $urandom_range(330),
                         $urandom_range(15) != 0, $urandom_range(9) != 0,
                         8'($urandom_range(255)));
            if (pick < 20) q.action = ACT_NEW;
            else if (pick < 32) q.action = ACT_DIRTY;
            else if (pick < 35) q.action = ACT_NONE;
            else if (pick < 40) begin
                q.space_num = $urandom;
                q.page_num = $urandom;
            end
            add_req(q);
        end
    endtask

    task automatic drain_results();
        while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial begin
        foreach (dir_used[i]) begin
            dir_used[i] = 1'b0;
            dir_dirty[i] = 1'b0;
            dir_space[i] = '0;
            dir_page[i] = '0;
            free_frames.insert(free_frames.size(), i);
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        add_req(make_req(ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'd0));
        add_req(make_req(ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF));
        add_req(make_req(ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'd0));
        add_req(make_req(ACT_NEW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0));
        add_req(make_req(ACT_NEW, 32'd0, 32'd0, 1'b0, 1'b0, 8'd0));
        add_req(make_req(ACT_GET, 32'd0, 32'd0, 1'b1, 1'b0, 8'd0));
        add_req(make_req(ACT_GET, 32'd5, 32'd9, 1'b1, 1'b0, 8'd0));
        add_req(make_req(ACT_DIRTY, 32'd0, 32'd0, 1'b0, 1'b0, 8'd0));
        add_req(make_req(ACT_DIRTY, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1, 8'd200));
        add_req(make_req(ACT_DIRTY, 32'd0, 32'd0, 1'b0, 1'b0, 8'hFF));
        add_req(make_req(ACT_NONE, 32'd1, 32'd1, 1'b1, 1'b1, 8'd1));
        add_req(make_req(ACT_GET, 32'd0, 32'd0, 1'b1, 1'b1, 8'd0));
        // Fill the pool and overflow it so that a full eviction batch with write-backs occurs.
        for (int i = 0; i < 256; i++)
            add_req(make_req(ACT_NEW, 32'd7, 32'(i), 1'b1, 1'b1, 8'd0));
        add_req(make_req(ACT_GET, 32'd8, 32'd1, 1'b1, 1'b0, 8'd0));
        add_req(make_req(ACT_GET, 32'd8, 32'd2, 1'b1, 1'b1, 8'd0));
        drain_results();

        queue_random(20);
        drain_results();

        send_idle_pct = 88;
        queue_random(20);
        drain_results();

        send_idle_pct = 0;
        recv_stall_pct = 88;
        queue_random(20);
        drain_results();

        send_idle_pct = 32;
        recv_stall_pct = 32;
        recv_hold = 1'b1;
        queue_random(20);
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
        drain_results();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(20);
        drain_results();

        if (errors == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
